/* design/byte_ring_fifo_top_defines.svh */
// ============================================================================
// Byte ring FIFO assertion macros
// Shared concurrent assertion macros; they expand to nothing under synthesis.
// ============================================================================
`ifndef BYTE_RING_FIFO_TOP_DEFINES_SVH
`define BYTE_RING_FIFO_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Checked property with a reset that disables it.
`define BRF_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked property that also holds during reset.
`define BRF_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BRF_ASSERT(label, clk, rst, prop, msg)
`define BRF_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

/* design/brf_pkg.sv */
// ============================================================================
// Byte ring FIFO package
// Field widths, command codes and the result side-band type.
// ============================================================================
package brf_pkg;

   localparam int CMD_W  = 3;
   localparam int BYTE_W = 8;
   localparam int AMT_W  = 11;
   localparam int CAP_W  = 11;
   localparam int CNT_W  = 10;

   localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH    = 3'd0,
      CMD_POP     = 3'd1,
      CMD_PEEK    = 3'd2,
      CMD_ADV_FRONT = 3'd3,
      CMD_ADV_REAR  = 3'd4,
      CMD_CLEAR   = 3'd5,
      CMD_STATUS  = 3'd6
   } cmd_type;

   // Per-request result information that travels alongside the memory read.
   typedef struct packed {
      logic             ok;
      logic             byte_en;
      logic [CNT_W-1:0] position;
   } rsp_meta_type;

endpackage

/* design/brf_if.sv */
// ============================================================================
// Byte ring FIFO channels
// Valid/ready request and response channels with their payloads.
// ============================================================================
interface brf_req_if
   import brf_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  cmd;
   logic [BYTE_W-1:0] data_in;
   logic [AMT_W-1:0]  amount;

   modport source (output valid, cmd, data_in, amount, input ready);
   modport sink   (input valid, cmd, data_in, amount, output ready);
endinterface

interface brf_rsp_if
   import brf_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] read_byte;
   logic              ok;
   logic [CNT_W-1:0]  position;
   logic [CNT_W-1:0]  used_bytes;
   logic [CNT_W-1:0]  free_bytes;
   logic [CNT_W-1:0]  contig_enqueue;
   logic [CNT_W-1:0]  contig_dequeue;

   modport source (output valid, read_byte, ok, position, used_bytes, free_bytes,
                   contig_enqueue, contig_dequeue, input ready);
   modport sink   (input valid, read_byte, ok, position, used_bytes, free_bytes,
                   contig_enqueue, contig_dequeue, output ready);
endinterface

/* design/byte_ring_fifo_top.sv */
// ============================================================================
// Byte ring FIFO top level
// Circular byte buffer with one empty slot, driven by one command a request.
// ============================================================================
//   Channel   Direction  Handshake         Contents
//   req_chan  in         valid/ready       cmd, data_in, amount
//   rsp_chan  out        valid/ready       read_byte, ok, position, counts
//   csr_*     in         write enable      capacity in use (11 bits)
//
// One request is taken every cycle while no response is held by a low rsp_chan.ready;
// its response appears in the next cycle, with the registered read of the byte store.
// Reset clears both pointers and sets the capacity to 1024; the store itself
// is not cleared and needs no clearing pass.
// A held response stalls the request side only while rsp_chan.ready is low.
`include "byte_ring_fifo_top_defines.svh"

module byte_ring_fifo_top
   import brf_pkg::*;
#(
   parameter int DEPTH = 1024
) (
   input  logic             clock,
   input  logic             reset,
   brf_req_if.sink          req_chan,
   brf_rsp_if.source        rsp_chan,
   input  logic             csr_we,
   input  logic [CAP_W-1:0] csr_wdata
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = AW + 1;

   logic              accept;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_meta_type      meta;
   rsp_meta_type      meta_ff;
   logic [AW-1:0]     front;
   logic [AW-1:0]     rear;
   logic [CW-1:0]     eff_cap;
   logic              ram_wr_en;
   logic [AW-1:0]     ram_wr_addr;
   logic              ram_rd_en;
   logic [AW-1:0]     ram_rd_addr;
   logic [BYTE_W-1:0] ram_rd_data;
   logic [CW-1:0]     used;
   logic [CW-1:0]     free;
   logic [CW-1:0]     contig_enq;
   logic [CW-1:0]     contig_deq;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   brf_ctrl #(.DEPTH(DEPTH), .AW(AW), .CW(CW)) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .cmd         (req_chan.cmd),
      .amount      (req_chan.amount),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .front       (front),
      .rear        (rear),
      .eff_cap     (eff_cap),
      .meta        (meta),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr)
   );

   brf_ram #(.WIDTH(BYTE_W), .DEPTH(DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (req_chan.data_in),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // The pointers only move on an accepted request or a capacity write, so while a
   // response is held they still describe the buffer after that request unless the capacity is written.
   brf_span #(.AW(AW), .CW(CW)) u_span_after (
      .front      (front),
      .rear       (rear),
      .cap        (eff_cap),
      .used       (used),
      .free       (free),
      .contig_enq (contig_enq),
      .contig_deq (contig_deq)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         meta_ff <= meta;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.read_byte      = meta_ff.byte_en ? ram_rd_data : '0;
   assign rsp_chan.ok             = meta_ff.ok;
   assign rsp_chan.position       = meta_ff.position;
   assign rsp_chan.used_bytes     = CNT_W'(used);
   assign rsp_chan.free_bytes     = CNT_W'(free);
   assign rsp_chan.contig_enqueue = CNT_W'(contig_enq);
   assign rsp_chan.contig_dequeue = CNT_W'(contig_deq);

   `BRF_ASSERT(a_ptr_range, clock, reset, (front < AW'(eff_cap - CW'(1)) || front == AW'(eff_cap - CW'(1))) && (rear < AW'(eff_cap - CW'(1)) || rear == AW'(eff_cap - CW'(1))), "pointer beyond capacity")
   `BRF_ASSERT_ALWAYS(a_ram_one_port, clock, !(ram_wr_en && ram_rd_en), "store read and written together")
   `BRF_ASSERT_ALWAYS(a_read_on_accept, clock, ram_rd_en |-> accept, "store read without a request")
   `BRF_ASSERT(a_hold_ptrs, clock, reset, (rsp_valid_ff && !rsp_chan.ready && !csr_we) |=> ($stable(front) && $stable(rear)), "pointers moved while a response was held")
   `BRF_ASSERT(a_count_sum, clock, reset, (used + free + CW'(1)) == eff_cap, "used and free space disagree with capacity")

endmodule

/* design/brf_ram.sv */
// ============================================================================
// Generic single-port-write RAM
// One write port and one read port; the read data is registered.
// ============================================================================
module brf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/brf_span.sv */
// ============================================================================
// Byte ring FIFO occupancy
// Used and free space and the contiguous spans for a pair of pointers.
// ============================================================================
module brf_span #(
   parameter int AW = 10,
   parameter int CW = 11
) (
   input  logic [AW-1:0] front,
   input  logic [AW-1:0] rear,
   input  logic [CW-1:0] cap,
   output logic [CW-1:0] used,
   output logic [CW-1:0] free,
   output logic [CW-1:0] contig_enq,
   output logic [CW-1:0] contig_deq
);

   logic [CW-1:0] f;
   logic [CW-1:0] r;

   assign f = CW'(front);
   assign r = CW'(rear);

   always_comb begin
      used = (f <= r) ? (r - f) : (cap - f + r);
      free = cap - used - CW'(1);
      // With the front at slot zero the last slot must stay empty.
      if (r < f) begin
         contig_enq = f - r - CW'(1);
      end else if (f == '0) begin
         contig_enq = cap - r - CW'(1);
      end else begin
         contig_enq = cap - r;
      end
      contig_deq = (f <= r) ? (r - f) : (cap - f);
   end

endmodule

/* design/brf_ctrl.sv */
// ============================================================================
// Byte ring FIFO control
// Capacity register, pointers and command decode for one request a cycle.
// ============================================================================
module brf_ctrl
   import brf_pkg::*;
#(
   parameter int DEPTH = 1024,
   parameter int AW    = 10,
   parameter int CW    = 11
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [CMD_W-1:0]  cmd,
   input  logic [AMT_W-1:0]  amount,
   input  logic              csr_we,
   input  logic [CAP_W-1:0]  csr_wdata,
   output logic [AW-1:0]     front,
   output logic [AW-1:0]     rear,
   output logic [CW-1:0]     eff_cap,
   output rsp_meta_type      meta,
   output logic              ram_wr_en,
   output logic [AW-1:0]     ram_wr_addr,
   output logic              ram_rd_en,
   output logic [AW-1:0]     ram_rd_addr
);

   localparam int XW = (CW > AMT_W) ? CW : AMT_W;

   logic [CAP_W-1:0] cap_ff, cap_in;
   logic [AW-1:0]    front_ff, front_in;
   logic [AW-1:0]    rear_ff, rear_in;
   logic [CW-1:0]    used;
   logic [CW-1:0]    free;
   logic [XW-1:0]    cap_x;
   logic [XW-1:0]    amt_x;
   logic             peek_hit;
   logic             rear_fits;
   logic [CW-1:0]    front_step;
   logic [CW-1:0]    rear_step;

   // Pointer plus a count below the capacity, wrapped once.
   function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] p,
                                              input logic [CW-1:0] n,
                                              input logic [CW-1:0] c);
      logic [CW-1:0] s;
      s = CW'(p) + n;
      if (s >= c) begin
         s = s - c;
      end
      return s[AW-1:0];
   endfunction

   // The capacity is saturated to the range the store supports.
   assign cap_x = XW'(cap_ff);
   always_comb begin
      if (cap_x < XW'(2)) begin
         eff_cap = CW'(2);
      end else if (cap_x > XW'(DEPTH)) begin
         eff_cap = CW'(DEPTH);
      end else begin
         eff_cap = CW'(cap_ff);
      end
   end

   brf_span #(.AW(AW), .CW(CW)) u_span_now (
      .front      (front_ff),
      .rear       (rear_ff),
      .cap        (eff_cap),
      .used       (used),
      .free       (free),
      .contig_enq (),
      .contig_deq ()
   );

   assign amt_x      = XW'(amount);
   assign peek_hit   = amt_x < XW'(used);
   assign rear_fits  = amt_x < XW'(free);
   assign front_step = peek_hit ? CW'(amount) : used;
   assign rear_step  = rear_fits ? CW'(amount) : free;

   always_comb begin
      cap_in      = cap_ff;
      front_in    = front_ff;
      rear_in     = rear_ff;
      meta        = '0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = rear_ff;
      ram_rd_en   = 1'b0;
      ram_rd_addr = front_ff;
      if (accept) begin
         unique case (cmd_type'(cmd))
            CMD_PUSH: begin
               if (free != '0) begin
                  ram_wr_en = 1'b1;
                  rear_in   = wrap_add(rear_ff, CW'(1), eff_cap);
                  meta.ok   = 1'b1;
               end
            end
            CMD_POP: begin
               if (used != '0) begin
                  ram_rd_en    = 1'b1;
                  front_in     = wrap_add(front_ff, CW'(1), eff_cap);
                  meta.ok      = 1'b1;
                  meta.byte_en = 1'b1;
               end
            end
            CMD_PEEK: begin
               ram_rd_addr = wrap_add(front_ff, front_step, eff_cap);
               if (peek_hit) begin
                  ram_rd_en    = 1'b1;
                  meta.ok      = 1'b1;
                  meta.byte_en = 1'b1;
               end
            end
            CMD_ADV_FRONT: begin
               front_in      = wrap_add(front_ff, front_step, eff_cap);
               meta.position = CNT_W'(front_in);
               meta.ok       = 1'b1;
            end
            CMD_ADV_REAR: begin
               rear_in       = wrap_add(rear_ff, rear_step, eff_cap);
               meta.position = CNT_W'(rear_in);
               meta.ok       = 1'b1;
            end
            CMD_CLEAR: begin
               front_in = '0;
               rear_in  = '0;
               meta.ok  = 1'b1;
            end
            CMD_STATUS: begin
               meta.ok = 1'b1;
            end
            default: begin
            end
         endcase
      end
      // A capacity write restarts the buffer empty.
      if (csr_we) begin
         cap_in   = csr_wdata;
         front_in = '0;
         rear_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff   <= CAP_RESET;
         front_ff <= '0;
         rear_ff  <= '0;
      end else begin
         cap_ff   <= cap_in;
         front_ff <= front_in;
         rear_ff  <= rear_in;
      end
   end

   assign front = front_ff;
   assign rear  = rear_ff;

endmodule
